@@ sv/dlr_pkg.sv @@
// Shared types and constants for the dashed line rasterizer.
// Holds field widths, item layouts, register indexes and the controller types.
// No dependencies.
package dlr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int DASH_BITS   = 8;
  localparam int INK_BITS    = 16;
  localparam int CANVAS_BITS = 11;
  localparam int PHASE_BITS  = DASH_BITS + 2;
  localparam int PER_BITS    = DASH_BITS + 1;
  localparam int ERR_BITS    = COORD_BITS + 2;
  localparam int E2_BITS     = ERR_BITS + 1;
  localparam int CMP_BITS    = ((COORD_BITS > CANVAS_BITS) ? COORD_BITS : CANVAS_BITS) + 1;
  localparam int NUM_BITS    = ((COORD_BITS > PHASE_BITS) ? COORD_BITS : PHASE_BITS) + 1;
  localparam int CNT_BITS    = $clog2(NUM_BITS + 1);

  // Input item layout, lowest bits first.
  localparam int IN_SX_LSB    = 0;
  localparam int IN_SY_LSB    = IN_SX_LSB + COORD_BITS;
  localparam int IN_EX_LSB    = IN_SY_LSB + COORD_BITS;
  localparam int IN_EY_LSB    = IN_EX_LSB + COORD_BITS;
  localparam int IN_ON_LSB    = IN_EY_LSB + COORD_BITS;
  localparam int IN_OFF_LSB   = IN_ON_LSB + DASH_BITS;
  localparam int IN_PH_LSB    = IN_OFF_LSB + DASH_BITS;
  localparam int IN_INK_LSB   = IN_PH_LSB + PHASE_BITS;
  localparam int IN_USED_BITS = IN_INK_LSB + INK_BITS;
  localparam int IN_DATA_BITS = ((IN_USED_BITS + 7) / 8) * 8;

  // Result item layout, lowest bits first.
  localparam int OUT_USED_BITS = 2 * COORD_BITS + INK_BITS + PER_BITS;
  localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CANVAS_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CANVAS_HEIGHT = 1'b1;

  localparam logic [CANVAS_BITS-1:0] CANVAS_WIDTH_RESET  = 11'd400;
  localparam logic [CANVAS_BITS-1:0] CANVAS_HEIGHT_RESET = 11'd300;

  // Item kind carried on tuser of the input channel.
  localparam logic MODE_LOAD = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD_PHASE,
    ST_MOD_SKIP
  } ctrl_state_t;

  typedef struct packed {
    logic load;       // latch a new segment and start the phase reduction
    logic tick;       // step the running segment by one pixel
    logic set_phase;  // take the reduced start phase into the dash counter
    logic emit_skip;  // send the result of a segment that is not drawn
  } ctrl_cmd_t;

  typedef struct packed {
    logic off_screen; // the offered load lies wholly beyond one canvas edge
    logic div_done;   // the remainder unit has finished
    logic out_free;   // the result register is empty or being emptied
  } dp_status_t;

endpackage

@@ sv/dlr_mod_unit.sv @@
// Iterative remainder unit: one restoring step per cycle, numerator MSB first.
// Used by the datapath to reduce dash phases modulo the dash period.
// Depends on dlr_pkg.
module dlr_mod_unit import dlr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [PER_BITS-1:0] den,
  output logic                done,
  output logic [PER_BITS-1:0] rem
);

  logic                run_r;
  logic                done_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [NUM_BITS-1:0] num_r;
  logic [PER_BITS-1:0] den_r;
  logic [PER_BITS-1:0] rem_r;
  logic [PER_BITS-1:0] rem_nxt;
  logic [PER_BITS:0]   trial;

  // The partial remainder stays below the divisor, so one subtract per bit is enough.
  always_comb begin
    trial = {rem_r, num_r[NUM_BITS-1]};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = PER_BITS'(trial - {1'b0, den_r});
    end else begin
      rem_nxt = trial[PER_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_BITS'(NUM_BITS);
    end else if (run_r) begin
      cnt_r  <= cnt_r - 1'b1;
      run_r  <= (cnt_r != CNT_BITS'(1));
      done_r <= (cnt_r == CNT_BITS'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (run_r) begin
      num_r <= {num_r[NUM_BITS-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

@@ sv/dlr_ctrl.sv @@
// Controller state machine of the dashed line rasterizer.
// Sequences item acceptance and the phase reduction; drives the datapath commands.
// Depends on dlr_pkg.
module dlr_ctrl import dlr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tuser,
  input  dp_status_t sts,
  output logic       in_tready,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && sts.out_free && (in_tuser == MODE_LOAD)) begin
          state_nxt = sts.off_screen ? ST_MOD_SKIP : ST_MOD_PHASE;
        end
      end
      ST_MOD_PHASE, ST_MOD_SKIP: begin
        if (sts.div_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = sts.out_free;
        if (in_tvalid && sts.out_free) begin
          if (in_tuser == MODE_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.tick = 1'b1;
          end
        end
      end
      ST_MOD_PHASE: cmd.set_phase = sts.div_done;
      ST_MOD_SKIP:  cmd.emit_skip = sts.div_done;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/dlr_datapath.sv @@
// Datapath of the dashed line rasterizer: canvas registers, segment state,
// Bresenham stepping, dash counter and the result register.
// Depends on dlr_pkg and dlr_mod_unit.
module dlr_datapath import dlr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [CANVAS_BITS-1:0]   cfg_wdata,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  input  ctrl_cmd_t                cmd,
  output dp_status_t               sts,
  input  logic                     out_tready,
  output logic                     out_tvalid,
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  output logic                     out_tuser,
  output logic                     out_tlast
);

  logic [CANVAS_BITS-1:0] canvas_w_r;
  logic [CANVAS_BITS-1:0] canvas_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_w_r <= CANVAS_WIDTH_RESET;
      canvas_h_r <= CANVAS_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CANVAS_WIDTH:  canvas_w_r <= cfg_wdata;
        REG_CANVAS_HEIGHT: canvas_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input fields.
  logic signed [COORD_BITS-1:0] x0, y0, x1, y1;
  logic [DASH_BITS-1:0]         on_in, off_in;
  logic [PHASE_BITS-1:0]        phase_in;
  logic [INK_BITS-1:0]          ink_in;

  assign x0       = in_tdata[IN_SX_LSB +: COORD_BITS];
  assign y0       = in_tdata[IN_SY_LSB +: COORD_BITS];
  assign x1       = in_tdata[IN_EX_LSB +: COORD_BITS];
  assign y1       = in_tdata[IN_EY_LSB +: COORD_BITS];
  assign on_in    = in_tdata[IN_ON_LSB +: DASH_BITS];
  assign off_in   = in_tdata[IN_OFF_LSB +: DASH_BITS];
  assign phase_in = in_tdata[IN_PH_LSB +: PHASE_BITS];
  assign ink_in   = in_tdata[IN_INK_LSB +: INK_BITS];

  // Signed coordinates and unsigned canvas sizes compared at a common width.
  logic signed [CMP_BITS-1:0] x0_e, y0_e, x1_e, y1_e, w_e, h_e;

  assign x0_e = CMP_BITS'(x0);
  assign y0_e = CMP_BITS'(y0);
  assign x1_e = CMP_BITS'(x1);
  assign y1_e = CMP_BITS'(y1);
  assign w_e  = $signed({{(CMP_BITS-CANVAS_BITS){1'b0}}, canvas_w_r});
  assign h_e  = $signed({{(CMP_BITS-CANVAS_BITS){1'b0}}, canvas_h_r});

  assign sts.off_screen = (x0[COORD_BITS-1] && x1[COORD_BITS-1]) ||
                          ((x0_e >= w_e) && (x1_e >= w_e)) ||
                          (y0[COORD_BITS-1] && y1[COORD_BITS-1]) ||
                          ((y0_e >= h_e) && (y1_e >= h_e));

  logic signed [COORD_BITS:0] diff_x, diff_y;
  logic [COORD_BITS-1:0]      dx_in, dy_in, steps_in;
  logic [NUM_BITS-1:0]        num_in;
  logic [PER_BITS-1:0]        period_in;

  always_comb begin
    diff_x    = $signed({x1[COORD_BITS-1], x1}) - $signed({x0[COORD_BITS-1], x0});
    diff_y    = $signed({y1[COORD_BITS-1], y1}) - $signed({y0[COORD_BITS-1], y0});
    dx_in     = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
    dy_in     = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
    steps_in  = (dx_in > dy_in) ? dx_in : dy_in;
    period_in = (on_in != '0) ? (PER_BITS'(on_in) + PER_BITS'(off_in)) : PER_BITS'(1);
    // A skipped segment still advances the phase by every pixel it would have had.
    if (sts.off_screen) begin
      num_in = NUM_BITS'(phase_in) + NUM_BITS'(steps_in) + NUM_BITS'(1);
    end else begin
      num_in = NUM_BITS'(phase_in);
    end
  end

  logic [PER_BITS-1:0] rem;

  dlr_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.load),
    .num   (num_in),
    .den   (period_in),
    .done  (sts.div_done),
    .rem   (rem)
  );

  // Segment state.
  logic                         busy_r;
  logic signed [COORD_BITS-1:0] cur_x_r, cur_y_r, tgt_x_r, tgt_y_r;
  logic [COORD_BITS-1:0]        abs_dx_r, abs_dy_r;
  logic signed [ERR_BITS-1:0]   err_r;
  logic                         dir_x_neg_r, dir_y_neg_r;
  logic [PER_BITS-1:0]          dash_pos_r;
  logic [DASH_BITS-1:0]         on_len_r, off_len_r;
  logic [INK_BITS-1:0]          ink_r;

  // Per-pixel step.
  logic                         emit_pixel;
  logic [PER_BITS-1:0]          period_r, dash_inc, dash_nxt;
  logic                         in_canvas, on_part, at_end;
  logic signed [CMP_BITS-1:0]   cx_e, cy_e;
  logic signed [E2_BITS-1:0]    e2, dx_w, dy_w;
  logic                         step_x, step_y;
  logic signed [ERR_BITS-1:0]   err_nxt;
  logic signed [COORD_BITS-1:0] cur_x_nxt, cur_y_nxt;

  always_comb begin
    emit_pixel = cmd.tick && busy_r;
    period_r   = (on_len_r != '0) ? (PER_BITS'(on_len_r) + PER_BITS'(off_len_r))
                                  : PER_BITS'(1);
    dash_inc   = dash_pos_r + PER_BITS'(1);
    dash_nxt   = (dash_inc >= period_r) ? '0 : dash_inc;
    cx_e       = CMP_BITS'(cur_x_r);
    cy_e       = CMP_BITS'(cur_y_r);
    in_canvas  = !cur_x_r[COORD_BITS-1] && !cur_y_r[COORD_BITS-1] &&
                 (cx_e < w_e) && (cy_e < h_e);
    on_part    = (on_len_r == '0) || (dash_pos_r < PER_BITS'(on_len_r));
    at_end     = (cur_x_r == tgt_x_r) && (cur_y_r == tgt_y_r);

    e2     = {err_r, 1'b0};
    dx_w   = $signed(E2_BITS'(abs_dx_r));
    dy_w   = $signed(E2_BITS'(abs_dy_r));
    step_x = e2 > -dy_w;
    step_y = e2 < dx_w;

    err_nxt = err_r;
    if (step_x) begin
      err_nxt = err_nxt - $signed(ERR_BITS'(abs_dy_r));
    end
    if (step_y) begin
      err_nxt = err_nxt + $signed(ERR_BITS'(abs_dx_r));
    end

    cur_x_nxt = cur_x_r;
    if (step_x) begin
      cur_x_nxt = dir_x_neg_r ? (cur_x_r - COORD_BITS'(1)) : (cur_x_r + COORD_BITS'(1));
    end
    cur_y_nxt = cur_y_r;
    if (step_y) begin
      cur_y_nxt = dir_y_neg_r ? (cur_y_r - COORD_BITS'(1)) : (cur_y_r + COORD_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (cmd.load) begin
      busy_r <= !sts.off_screen;
    end else if (emit_pixel && at_end) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      on_len_r  <= on_in;
      off_len_r <= off_in;
      ink_r     <= ink_in;
      if (!sts.off_screen) begin
        cur_x_r     <= x0;
        cur_y_r     <= y0;
        tgt_x_r     <= x1;
        tgt_y_r     <= y1;
        abs_dx_r    <= dx_in;
        abs_dy_r    <= dy_in;
        err_r       <= ERR_BITS'(dx_in) - ERR_BITS'(dy_in);
        dir_x_neg_r <= !(diff_x > 0);
        dir_y_neg_r <= !(diff_y > 0);
      end
    end else if (emit_pixel) begin
      dash_pos_r <= dash_nxt;
      if (!at_end) begin
        cur_x_r <= cur_x_nxt;
        cur_y_r <= cur_y_nxt;
        err_r   <= err_nxt;
      end
    end
    if (cmd.set_phase) begin
      dash_pos_r <= rem;
    end
  end

  // Result register.
  logic                         out_valid_r;
  logic signed [COORD_BITS-1:0] px_r, py_r;
  logic [INK_BITS-1:0]          pink_r;
  logic                         paint_r, last_r;
  logic [PER_BITS-1:0]          phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_pixel || cmd.emit_skip) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_pixel) begin
      px_r    <= cur_x_r;
      py_r    <= cur_y_r;
      pink_r  <= ink_r;
      paint_r <= on_part && in_canvas;
      last_r  <= at_end;
      phase_r <= at_end ? dash_nxt : '0;
    end else if (cmd.emit_skip) begin
      px_r    <= '0;
      py_r    <= '0;
      pink_r  <= '0;
      paint_r <= 1'b0;
      last_r  <= 1'b1;
      phase_r <= rem;
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = OUT_DATA_BITS'({phase_r, pink_r, py_r, px_r});
  assign out_tuser    = paint_r;
  assign out_tlast    = last_r;

endmodule

@@ sv/dashed_line_rasterizer_unit.sv @@
// Top level of the dashed line rasterizer: controller plus datapath.
// Depends on dlr_pkg, dlr_ctrl, dlr_datapath (and dlr_mod_unit below it).
//
//  Channel  | Direction | Handshake          | Contents
//  in_      | input     | tvalid / tready    | tdata: start_x, start_y, end_x, end_y,
//           |           |                    |   dash_on, dash_off, start_phase, ink; tuser: mode
//  out_     | output    | tvalid / tready    | tdata: pixel_x, pixel_y, pixel_ink, end_phase;
//           |           |                    |   tuser: paint; tlast: last
//  cfg_     | input     | cfg_we             | cfg_idx: register index; cfg_wdata: value
//
// Tick items stream pixels at one per cycle while the output is taken.
// After a load item the next item is accepted only once the phase reduction is through: the
// accept, one step per numerator bit in the iterative remainder unit, and taking the
// remainder once the unit reports done.
// Reset is synchronous and active low; it clears control state and loads the canvas size.
// An item is accepted only while the result register is empty or being emptied.
module dashed_line_rasterizer_unit import dlr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [CANVAS_BITS-1:0]   cfg_wdata,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // from bit 0: start_x, start_y, end_x, end_y, dash_on, dash_off, start_phase, ink, zero pad
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  // mode
  input  logic                     in_tuser,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // from bit 0: pixel_x, pixel_y, pixel_ink, end_phase, zero pad
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  // paint
  output logic                     out_tuser,
  output logic                     out_tlast
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  dlr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .sts       (sts),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  dlr_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  a_ready_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!out_tvalid || out_tready))
    else $error("input accepted while the result register is held");

  a_load_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == MODE_LOAD)) |=> !in_tready)
    else $error("input accepted during phase reduction");

  a_skip_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_skip |=> (out_tvalid && out_tlast))
    else $error("skipped segment gave no final result");

  a_one_finish: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.set_phase && cmd.emit_skip) && !((cmd.set_phase || cmd.emit_skip) && in_tready))
    else $error("remainder consumed twice or while accepting input");
`endif

endmodule
